// ===== hw/rtl/mhse_pkg.sv =====
// Shared constants, types and key compare for the min-heap sift engine.
`default_nettype none

package mhse_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int KEY_WIDTH  = 32;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = IDX_W + 1;
  localparam int SWAP_W     = 4;

  localparam logic [SWAP_W-1:0] SWAP_MAX = {SWAP_W{1'b1}};

  typedef logic [KEY_WIDTH-1:0] key_t;

  // Command codes carried in the input word
  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_SWIM  = 3'd2,
    CMD_SINK  = 3'd3,
    CMD_BUILD = 3'd4
  } cmd_t;

  // Configuration register indexes
  localparam logic CFG_HEAP_SIZE  = 1'b0;
  localparam logic CFG_KEY_SIGNED = 1'b1;

  // Outcome of one sift level
  typedef struct packed {
    logic             move;
    logic [IDX_W-1:0] next_idx;
    key_t             move_key;
  } step_t;

  // True when key a is strictly less than key b
  function automatic logic key_less(input key_t a, input key_t b, input logic sgn);
    key_t ax;
    key_t bx;
    ax = a;
    bx = b;
    if (sgn) begin
      ax[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
      bx[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
    end
    return ax < bx;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/min_heap_sift_engine.sv =====
// Top level of the min-heap sift engine: command sequencer and key store.
`default_nettype none

// Binary min-heap engine with the keys in one on-chip store of HEAP_DEPTH
// words (two registered read ports, one write port). One command is taken at
// a time and gives one result word. Write, unused codes and bad indexes go
// straight to the done state; read passes through the load state first. Swim
// and sink run load and compare, then fetch and compare again for each swap:
// every level needs one store read of the parent (or both children) followed
// by a compare and write-back. Build runs a swim for every index from 1 to
// size-1, each opened by a build read state. The store needs no clearing pass
// after reset; entries that were never written read as garbage.
module min_heap_sift_engine import mhse_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data,
  // command channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        cmd,
  input  wire logic [IDX_W-1:0]  entry_index,
  input  wire logic [31:0]       key_in,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   status,
  output logic [SWAP_W-1:0]      swap_count,
  output logic [31:0]            key_out
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_FETCH  = 6'b000100,
    S_CMP    = 6'b001000,
    S_BLD_RD = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [SIZE_W-1:0] heap_size;
  logic              key_signed;
  logic [SIZE_W-1:0] eff_size;

  logic [2:0]        cmd_r;
  logic [IDX_W-1:0]  idx;
  logic [SIZE_W-1:0] bld_idx;
  logic [SIZE_W-1:0] bld_idx_inc;
  key_t              cur_key;
  logic [SWAP_W-1:0] swaps;
  logic              status_r;
  key_t              key_r;

  key_t              mem [HEAP_DEPTH];
  key_t              rd_a;
  key_t              rd_b;
  logic [IDX_W-1:0]  addr_a;
  logic [IDX_W-1:0]  addr_b;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  key_t              wr_data;

  logic              accept;
  logic              bad_idx;
  logic              out_free;
  logic              sink_mode;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W:0]    left;
  step_t             step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size  <= '0;
      key_signed <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_SIZE:  heap_size  <= cfg_data;
        CFG_KEY_SIGNED: key_signed <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Saturate the size to the store depth
  assign eff_size = (heap_size > SIZE_W'(HEAP_DEPTH)) ? SIZE_W'(HEAP_DEPTH) : heap_size;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign bad_idx   = (cmd <= CMD_SINK) && ({1'b0, entry_index} >= eff_size);
  assign out_free  = !out_valid || !out_stall;
  assign sink_mode = (cmd_r == CMD_SINK);
  assign parent    = (idx - IDX_W'(1)) >> 1;
  assign left      = {idx, 1'b1};
  assign bld_idx_inc = bld_idx + SIZE_W'(1);

  mhse_sift_step u_step (
    .sink_mode  (sink_mode),
    .key_signed (key_signed),
    .idx        (idx),
    .size       (eff_size),
    .cur_key    (cur_key),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .step       (step)
  );

  // Select store read addresses
  always_comb begin
    unique case (state)
      S_IDLE:          addr_a = entry_index;
      S_LOAD, S_FETCH: addr_a = sink_mode ? left[IDX_W-1:0] : parent;
      default:         addr_a = idx;
    endcase
    addr_b = left[IDX_W-1:0] + IDX_W'(1);
  end

  // Select store write: direct write command or sift write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = cur_key;
    if (accept && (cmd == CMD_WRITE) && !bad_idx) begin
      wr_en   = 1'b1;
      wr_addr = entry_index;
      wr_data = key_in;
    end else if (state == S_CMP) begin
      wr_en   = 1'b1;
      wr_data = step.move ? step.move_key : cur_key;
    end
  end

  // Key store with registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (bad_idx) begin
            state_next = S_DONE;
          end else if (cmd == CMD_READ || cmd == CMD_SWIM || cmd == CMD_SINK) begin
            state_next = S_LOAD;
          end else if (cmd == CMD_BUILD && eff_size > SIZE_W'(1)) begin
            state_next = S_BLD_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_LOAD:   state_next = (cmd_r == CMD_READ) ? S_DONE : S_CMP;
      S_FETCH:  state_next = S_CMP;
      S_CMP: begin
        priority if (step.move) begin
          state_next = S_FETCH;
        end else if (cmd_r == CMD_BUILD && bld_idx_inc < eff_size) begin
          state_next = S_BLD_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BLD_RD: state_next = S_LOAD;
      S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r    <= cmd;
          idx      <= (cmd == CMD_BUILD) ? IDX_W'(1) : entry_index;
          bld_idx  <= SIZE_W'(1);
          swaps    <= '0;
          status_r <= bad_idx;
          key_r    <= '0;
        end
      end
      S_LOAD: begin
        if (cmd_r == CMD_READ) begin
          key_r <= rd_a;
        end else begin
          cur_key <= rd_a;
        end
      end
      S_CMP: begin
        if (step.move) begin
          idx <= step.next_idx;
          if (swaps != SWAP_MAX) begin
            swaps <= swaps + SWAP_W'(1);
          end
        end else if (cmd_r == CMD_BUILD) begin
          bld_idx <= bld_idx_inc;
          idx     <= bld_idx_inc[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register: load the result word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status     <= status_r;
      swap_count <= (cmd_r == CMD_BUILD) ? '0 : swaps;
      key_out    <= key_r;
    end
  end

  // Store writes only come from a direct write or a sift write-back
  a_wr_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE || state == S_CMP))
    else $error("store write outside accept or compare");

  // A result word appears only after the sequencer finished a command
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised without finished command");

  // Each build swim starts at the build counter
  a_build_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_BLD_RD |-> idx == bld_idx[IDX_W-1:0])
    else $error("build index out of step");

endmodule

`default_nettype wire

// ===== hw/rtl/mhse_sift_step.sv =====
// One level of swim or sink: compare the moving key with parent or children.
`default_nettype none

module mhse_sift_step import mhse_pkg::*; (
  input  wire logic              sink_mode,
  input  wire logic              key_signed,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [SIZE_W-1:0] size,
  input  wire key_t              cur_key,
  input  wire key_t              rd_a,
  input  wire key_t              rd_b,
  output step_t                  step
);

  logic [IDX_W+1:0] left;
  logic [IDX_W+1:0] right;
  logic [IDX_W+1:0] size_ext;
  logic [IDX_W-1:0] parent;
  logic             take_left;
  logic             take_right;
  key_t             best_key;

  assign left     = {1'b0, idx, 1'b1};
  assign right    = left + (IDX_W+2)'(1);
  assign size_ext = {1'b0, size};
  assign parent   = (idx - IDX_W'(1)) >> 1;

  // Pick the strictly smaller child, left wins ties
  always_comb begin
    take_left  = (left < size_ext) && key_less(rd_a, cur_key, key_signed);
    best_key   = take_left ? rd_a : cur_key;
    take_right = (right < size_ext) && key_less(rd_b, best_key, key_signed);
  end

  // Decide whether the key moves one level
  always_comb begin
    if (sink_mode) begin
      step.move     = take_left || take_right;
      step.next_idx = take_right ? right[IDX_W-1:0] : left[IDX_W-1:0];
      step.move_key = take_right ? rd_b : rd_a;
    end else begin
      step.move     = (idx != '0) && key_less(cur_key, rd_a, key_signed);
      step.next_idx = parent;
      step.move_key = rd_a;
    end
  end

endmodule

`default_nettype wire
